### src/dbs_pkg.sv
// Shared types, codes and index helpers for the deque and bag store.
package dbs_pkg;

    // Storage geometry
    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int VAL_W = 32;

    // Action codes; codes six and seven are undefined and do nothing
    typedef enum logic [2:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_CONTAINS   = 3'd4,
        ACT_REMOVE     = 3'd5
    } t_action;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_MISSING = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_RD_FRONT,
        S_RD_BACK,
        S_LOAD
    } t_seq_state;

    typedef struct packed {
        logic [2:0]              action;
        logic signed [VAL_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        t_status                 status;
        logic                    found;
        logic [CNT_W-1:0]        count;
        logic signed [VAL_W-1:0] front_value;
        logic signed [VAL_W-1:0] back_value;
    } t_out_item;

    // One access slot of the entry memory per cycle
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [VAL_W-1:0] wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } t_mem_req;

    // Physical slot of logical position pos from the head (circular)
    function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                                 input logic [CNT_W-1:0] pos);
        logic [CNT_W:0] sum;
        sum = {{(CNT_W + 1 - IDX_W){1'b0}}, head} + {1'b0, pos};
        if (sum >= (CNT_W + 1)'(DEPTH)) begin
            sum = sum - (CNT_W + 1)'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    // Slot one before the head, wrapping at zero
    function automatic logic [IDX_W-1:0] slot_dec(input logic [IDX_W-1:0] head);
        logic [IDX_W-1:0] res;
        if (head == '0) begin
            res = IDX_W'(DEPTH - 1);
        end else begin
            res = head - 1'b1;
        end
        return res;
    endfunction

endpackage

### src/deque_bag_store_top.sv
// Deque and bag store: input handshake, sequencer, entry memory, result register.
//
// Input channel: i_valid / o_stall with i_item (action, value). An item
// transfers at a clock edge with i_valid high and o_stall low. o_stall is
// high while an item is being worked on.
// Output channel: o_valid / i_stall with o_result (status, found, count,
// front_value, back_value). One result per input item, in order.
// Pushes, pops and undefined actions go from transfer through the front read,
// the back read and the result load. Contains walks the stored entries one per
// cycle through the single memory read port. Remove then rewrites each entry
// behind the match, one per cycle, once the read pipeline has filled and until
// it drains. The next item is taken in the cycle after the result is loaded.
// A finished result waits in the output register while the next item is
// already being worked on; that item holds in its last step until the
// receiver takes the waiting result.
// Reset (i_rst_n low, synchronous) empties the store and drops any result.
module deque_bag_store_top
    import dbs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_result
);

    t_mem_req         mem_req;
    logic [VAL_W-1:0] mem_rdata;
    logic             seq_idle;
    logic             res_valid;
    t_out_item        res;
    logic             out_busy;
    logic             r_out_valid, n_out_valid;
    t_out_item        r_out, n_out;

    dbs_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_valid && seq_idle),
        .i_item      (i_item),
        .i_out_busy  (out_busy),
        .i_rdata     (mem_rdata),
        .o_idle      (seq_idle),
        .o_req       (mem_req),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    dbs_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    // Output register is busy when its result will not transfer this cycle
    assign out_busy = r_out_valid && i_stall;

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (res_valid) begin
            n_out_valid = 1'b1;
            n_out       = res;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_stall  = !seq_idle;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

### src/dbs_mem.sv
// Entry memory: one write port and one registered read port.
module dbs_mem
    import dbs_pkg::*;
(
    input  logic             i_clk,
    input  t_mem_req         i_req,
    output logic [VAL_W-1:0] o_rdata
);

    logic [VAL_W-1:0] r_mem [DEPTH];
    logic [VAL_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // Registered read port, holds its data between reads
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/dbs_seq.sv
// Sequencer: decodes actions, walks the store for search and gap closing,
// then fetches front and back values for the result.
module dbs_seq
    import dbs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  t_in_item         i_item,
    input  logic             i_out_busy,
    input  logic [VAL_W-1:0] i_rdata,
    output logic             o_idle,
    output t_mem_req         o_req,
    output logic             o_res_valid,
    output t_out_item        o_res
);

    t_seq_state       r_state, n_state;
    logic [IDX_W-1:0] r_head, n_head;
    logic [CNT_W-1:0] r_count, n_count;
    logic [VAL_W-1:0] r_value, n_value;
    logic             r_remove, n_remove;
    logic [CNT_W-1:0] r_rd_idx, n_rd_idx;
    logic [CNT_W-1:0] r_cmp_idx, n_cmp_idx;
    logic             r_vld, n_vld;
    logic [CNT_W-1:0] r_wr_idx, n_wr_idx;
    t_status          r_status, n_status;
    logic             r_found, n_found;
    logic [VAL_W-1:0] r_front, n_front;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_vld   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_vld   <= n_vld;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_value   <= n_value;
        r_remove  <= n_remove;
        r_rd_idx  <= n_rd_idx;
        r_cmp_idx <= n_cmp_idx;
        r_wr_idx  <= n_wr_idx;
        r_status  <= n_status;
        r_found   <= n_found;
        r_front   <= n_front;
    end

    // Next state and memory accesses
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_value     = r_value;
        n_remove    = r_remove;
        n_rd_idx    = r_rd_idx;
        n_cmp_idx   = r_cmp_idx;
        n_vld       = r_vld;
        n_wr_idx    = r_wr_idx;
        n_status    = r_status;
        n_found     = r_found;
        n_front     = r_front;
        o_req       = '0;
        o_res_valid = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_status = ST_OK;
                    n_found  = 1'b0;
                    n_state  = S_RD_FRONT;
                    case (i_item.action)
                        ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
                            if (r_count == CNT_W'(DEPTH)) begin
                                n_status = ST_FULL;
                            end else begin
                                o_req.we    = 1'b1;
                                o_req.wdata = i_item.value;
                                n_count     = r_count + 1'b1;
                                if (i_item.action == ACT_PUSH_FRONT) begin
                                    o_req.waddr = slot_dec(r_head);
                                    n_head      = slot_dec(r_head);
                                end else begin
                                    o_req.waddr = slot_of(r_head, r_count);
                                end
                            end
                        end
                        ACT_POP_FRONT, ACT_POP_BACK: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_count = r_count - 1'b1;
                                if (i_item.action == ACT_POP_FRONT) begin
                                    n_head = slot_of(r_head, CNT_W'(1));
                                end
                            end
                        end
                        ACT_CONTAINS, ACT_REMOVE: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_value  = i_item.value;
                                n_remove = (i_item.action == ACT_REMOVE);
                                n_rd_idx = '0;
                                n_vld    = 1'b0;
                                n_state  = S_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // Read one entry a cycle, compare the one read the cycle before
            S_SCAN: begin
                if (r_rd_idx < r_count) begin
                    o_req.re    = 1'b1;
                    o_req.raddr = slot_of(r_head, r_rd_idx);
                    n_rd_idx    = r_rd_idx + 1'b1;
                    n_cmp_idx   = r_rd_idx;
                    n_vld       = 1'b1;
                end else begin
                    n_vld = 1'b0;
                end
                if (r_vld) begin
                    if (i_rdata == r_value) begin
                        n_found = 1'b1;
                        n_vld   = 1'b0;
                        if (r_remove) begin
                            n_wr_idx = r_cmp_idx;
                            n_rd_idx = r_cmp_idx + 1'b1;
                            n_state  = S_SHIFT;
                        end else begin
                            n_state = S_RD_FRONT;
                        end
                    end else if (r_cmp_idx == r_count - 1'b1) begin
                        n_status = ST_MISSING;
                        n_vld    = 1'b0;
                        n_state  = S_RD_FRONT;
                    end
                end
            end

            // Move later entries one place toward the front
            S_SHIFT: begin
                if (r_vld) begin
                    o_req.we    = 1'b1;
                    o_req.waddr = slot_of(r_head, r_wr_idx);
                    o_req.wdata = i_rdata;
                    n_wr_idx    = r_wr_idx + 1'b1;
                end
                if (r_rd_idx < r_count) begin
                    o_req.re    = 1'b1;
                    o_req.raddr = slot_of(r_head, r_rd_idx);
                    n_rd_idx    = r_rd_idx + 1'b1;
                    n_vld       = 1'b1;
                end else begin
                    n_vld = 1'b0;
                    if (!r_vld) begin
                        n_count = r_count - 1'b1;
                        n_state = S_RD_FRONT;
                    end
                end
            end

            S_RD_FRONT: begin
                o_req.re    = 1'b1;
                o_req.raddr = r_head;
                n_state     = S_RD_BACK;
            end

            S_RD_BACK: begin
                o_req.re    = 1'b1;
                o_req.raddr = slot_of(r_head, r_count - 1'b1);
                n_front     = i_rdata;
                n_state     = S_LOAD;
            end

            // Back value sits in the read register; hand result over
            S_LOAD: begin
                if (!i_out_busy) begin
                    o_res_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Result fields; an empty store reports zeros
    always_comb begin
        o_res.status = r_status;
        o_res.found  = r_found;
        o_res.count  = r_count;
        if (r_count == '0) begin
            o_res.front_value = '0;
            o_res.back_value  = '0;
        end else begin
            o_res.front_value = r_front;
            o_res.back_value  = i_rdata;
        end
    end

    assign o_idle = (r_state == S_IDLE);

endmodule
